// ----- src/slcp_pkg.sv -----
package slcp_pkg;

	localparam int MAX_COMMAND_BYTES = 10;
	localparam int POS_W   = $clog2(MAX_COMMAND_BYTES + 1);
	localparam int BYTE_W  = 8;
	localparam int LED_W   = 8;
	localparam int HALF_W  = 16;
	localparam int PHASE_W = HALF_W + 1;

	localparam logic [HALF_W-1:0] HALF_PERIOD_RESET = 16'd500;

	localparam logic [BYTE_W-1:0] CHAR_HASH  = 8'h23;
	localparam logic [BYTE_W-1:0] CHAR_STAR  = 8'h2A;
	localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;
	localparam logic [BYTE_W-1:0] CHAR_ONE   = 8'h31;
	localparam logic [BYTE_W-1:0] CHAR_EIGHT = 8'h38;
	localparam logic [BYTE_W-1:0] CHAR_B     = 8'h42;
	localparam logic [BYTE_W-1:0] CHAR_F     = 8'h46;
	localparam logic [BYTE_W-1:0] CHAR_I     = 8'h49;
	localparam logic [BYTE_W-1:0] CHAR_K     = 8'h4B;
	localparam logic [BYTE_W-1:0] CHAR_L     = 8'h4C;
	localparam logic [BYTE_W-1:0] CHAR_N     = 8'h4E;
	localparam logic [BYTE_W-1:0] CHAR_O     = 8'h4F;

	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_TICK = 1'b1;

	typedef logic [MAX_COMMAND_BYTES-1:0][BYTE_W-1:0] cmd_buf_t;

	typedef enum logic [1:0] {
		CMD_ON    = 2'd0,
		CMD_OFF   = 2'd1,
		CMD_BLINK = 2'd2
	} cmd_kind_t;

	typedef struct packed {
		logic             done;
		logic             matched;
		cmd_kind_t        kind;
		logic [LED_W-1:0] target;
	} cmd_t;

	typedef struct packed {
		logic apply;
		logic tick;
		cmd_t cmd;
	} step_t;

endpackage

// ----- src/slcp_if.sv -----
interface slcp_req_if;
	logic                       valid;
	logic                       ready;
	logic                       operation;
	logic [slcp_pkg::BYTE_W-1:0] rx_byte;

	modport source (output valid, output operation, output rx_byte, input ready);
	modport sink (input valid, input operation, input rx_byte, output ready);
endinterface

interface slcp_res_if;
	logic                       valid;
	logic                       ready;
	logic [slcp_pkg::LED_W-1:0] led_levels;
	logic                       command_done;
	logic                       command_matched;

	modport source (output valid, output led_levels, output command_done,
		output command_matched, input ready);
	modport sink (input valid, input led_levels, input command_done,
		input command_matched, output ready);
endinterface

interface slcp_cfg_if;
	logic                        valid;
	logic                        ready;
	logic [slcp_pkg::HALF_W-1:0] blink_half_period;

	modport source (output valid, output blink_half_period, input ready);
	modport sink (input valid, input blink_half_period, output ready);
endinterface

// ----- src/slcp_cmd_decode.sv -----
module slcp_cmd_decode (
	input  slcp_pkg::cmd_buf_t                 buf_q,
	input  logic [slcp_pkg::POS_W-1:0]         pos,
	input  logic [slcp_pkg::BYTE_W-1:0]        rx_byte,
	output logic [slcp_pkg::POS_W-1:0]         wr_pos,
	output logic [slcp_pkg::POS_W-1:0]         pos_next,
	output slcp_pkg::cmd_t                     cmd
);
	import slcp_pkg::*;

	localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_COMMAND_BYTES);

	function automatic logic [LED_W-1:0] tail_leds(
		input logic [BYTE_W-1:0] p0,
		input logic [BYTE_W-1:0] p1,
		input logic [BYTE_W-1:0] p2,
		input logic              rest_two,
		input logic              rest_three
	);
		logic [LED_W-1:0] t;
		t = '0;
		if (rest_two && p0 == CHAR_STAR && p1 == CHAR_HASH) begin
			t = '1;
		end else if (rest_three && p0 == CHAR_ZERO && p1 >= CHAR_ONE && p1 <= CHAR_EIGHT
				&& p2 == CHAR_HASH) begin
			t = LED_W'(1) << 3'(p1 - CHAR_ONE);
		end
		return t;
	endfunction

	logic [BYTE_W-1:0] cmd_bytes [MAX_COMMAND_BYTES];
	logic [POS_W-1:0]  len;
	logic [LED_W-1:0]  t_on;
	logic [LED_W-1:0]  t_off;
	logic [LED_W-1:0]  t_blink;
	logic              done;

	always_comb begin
		wr_pos = (pos >= POS_MAX) ? '0 : pos;
		len = wr_pos + POS_W'(1);
		for (int i = 0; i < MAX_COMMAND_BYTES; i++) begin
			cmd_bytes[i] = (POS_W'(i) == wr_pos) ? rx_byte : buf_q[i];
		end

		t_on = '0;
		if (cmd_bytes[0] == CHAR_O && cmd_bytes[1] == CHAR_N) begin
			t_on = tail_leds(cmd_bytes[2], cmd_bytes[3], cmd_bytes[4],
				len == POS_W'(4), len == POS_W'(5));
		end
		t_off = '0;
		if (cmd_bytes[0] == CHAR_O && cmd_bytes[1] == CHAR_F && cmd_bytes[2] == CHAR_F) begin
			t_off = tail_leds(cmd_bytes[3], cmd_bytes[4], cmd_bytes[5],
				len == POS_W'(5), len == POS_W'(6));
		end
		t_blink = '0;
		if (cmd_bytes[0] == CHAR_B && cmd_bytes[1] == CHAR_L && cmd_bytes[2] == CHAR_I
				&& cmd_bytes[3] == CHAR_N && cmd_bytes[4] == CHAR_K) begin
			t_blink = tail_leds(cmd_bytes[5], cmd_bytes[6], cmd_bytes[7],
				len == POS_W'(7), len == POS_W'(8));
		end

		done = (rx_byte == CHAR_HASH) || (len >= POS_MAX);
		pos_next = done ? '0 : len;

		cmd.done = done;
		cmd.kind = CMD_ON;
		cmd.target = '0;
		if (t_on != '0) begin
			cmd.kind = CMD_ON;
			cmd.target = t_on;
		end else if (t_off != '0) begin
			cmd.kind = CMD_OFF;
			cmd.target = t_off;
		end else if (t_blink != '0) begin
			cmd.kind = CMD_BLINK;
			cmd.target = t_blink;
		end
		cmd.matched = done && (cmd.target != '0);
	end

endmodule

// ----- src/slcp_led_ctrl.sv -----
module slcp_led_ctrl (
	input  logic                         clk,
	input  logic                         arst_n,
	input  slcp_pkg::step_t              step,
	input  logic                         cfg_we,
	input  logic [slcp_pkg::HALF_W-1:0]  cfg_half,
	output logic [slcp_pkg::LED_W-1:0]   led_next
);
	import slcp_pkg::*;

	logic [LED_W-1:0]   led_q;
	logic [LED_W-1:0]   mask_q;
	logic [PHASE_W-1:0] phase_q;
	logic [HALF_W-1:0]  half_q;
	logic [LED_W-1:0]   mask_next;
	logic [PHASE_W-1:0] phase_next;

	always_comb begin
		led_next = led_q;
		mask_next = mask_q;
		phase_next = phase_q;
		if (step.tick) begin
			if (mask_q != '0) begin
				if (phase_q < {1'b0, half_q}) begin
					led_next = led_q | mask_q;
					phase_next = phase_q + PHASE_W'(1);
				end else if (phase_q < {half_q, 1'b0}) begin
					led_next = led_q & ~mask_q;
					phase_next = phase_q + PHASE_W'(1);
				end else begin
					phase_next = '0;
				end
			end
		end else if (step.cmd.matched) begin
			case (step.cmd.kind)
				CMD_ON: begin
					led_next = led_q | step.cmd.target;
					mask_next = mask_q & ~step.cmd.target;
				end
				CMD_OFF: begin
					led_next = led_q & ~step.cmd.target;
					mask_next = mask_q & ~step.cmd.target;
				end
				CMD_BLINK: begin
					mask_next = mask_q | step.cmd.target;
				end
				default: begin
					led_next = led_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			led_q <= '0;
			mask_q <= '0;
			phase_q <= '0;
		end else if (step.apply) begin
			led_q <= led_next;
			mask_q <= mask_next;
			phase_q <= phase_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_q <= HALF_PERIOD_RESET;
		end else if (cfg_we) begin
			half_q <= cfg_half;
		end
	end

endmodule

// ----- src/serial_led_command_parser.sv -----
// An accepted input goes to the input register, and its result then enters the result
// register; while the result side stalls, the item waits in the input register.
// Throughput: one item per cycle unless result.ready stalls; the input register accepts
// the next item while a finished result waits in the result register.
// Reset: arst_n clears LEDs, blink mask, blink phase and command position at once and
// loads a half period of 500 ticks. Command buffer bytes are not reset.
module serial_led_command_parser (
	input logic        clk,
	input logic        arst_n,
	slcp_req_if.sink   request,
	slcp_res_if.source result,
	slcp_cfg_if.sink   cfg
);
	import slcp_pkg::*;

	logic              valid_s1;
	logic              op_s1;
	logic [BYTE_W-1:0] byte_s1;

	logic              valid_s2;
	logic [LED_W-1:0]  led_s2;
	logic              done_s2;
	logic              matched_s2;

	cmd_buf_t          buf_q;
	logic [POS_W-1:0]  pos_q;
	logic [POS_W-1:0]  wr_pos;
	logic [POS_W-1:0]  pos_next;
	cmd_t              cmd;
	step_t             step;
	logic [LED_W-1:0]  led_next;
	logic              advance;
	logic              is_byte;

	assign advance = valid_s1 && (!valid_s2 || result.ready);
	assign is_byte = (op_s1 == OP_BYTE);
	assign request.ready = !valid_s1 || advance;
	assign cfg.ready = 1'b1;

	assign result.valid = valid_s2;
	assign result.led_levels = led_s2;
	assign result.command_done = done_s2;
	assign result.command_matched = matched_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (request.ready) begin
			valid_s1 <= request.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (request.ready && request.valid) begin
			op_s1 <= request.operation;
			byte_s1 <= request.rx_byte;
		end
	end

	slcp_cmd_decode u_decode (
		.buf_q    (buf_q),
		.pos      (pos_q),
		.rx_byte  (byte_s1),
		.wr_pos   (wr_pos),
		.pos_next (pos_next),
		.cmd      (cmd)
	);

	always_comb begin
		step.apply = advance;
		step.tick = !is_byte;
		step.cmd = cmd;
	end

	slcp_led_ctrl u_led_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.cfg_we   (cfg.valid),
		.cfg_half (cfg.blink_half_period),
		.led_next (led_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (advance && is_byte) begin
			pos_q <= pos_next;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && is_byte) begin
			buf_q[wr_pos] <= byte_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (result.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			led_s2 <= led_next;
			done_s2 <= is_byte && cmd.done;
			matched_s2 <= is_byte && cmd.matched;
		end
	end

endmodule

// ----- tb/tb_serial_led_command_parser.sv -----
`timescale 1ns / 100ps

module tb_serial_led_command_parser;
	import slcp_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int HOLD_CYCLES    = 200;
	localparam int DRAIN_CYCLES   = 8;
	localparam int MAX_REPORTS    = 10;

	typedef struct packed {
		logic [LED_W-1:0] leds;
		logic             done;
		logic             matched;
	} led_result_t;

	typedef logic [BYTE_W-1:0] byte_seq_t[$];

	logic clk;
	logic arst_n;

	slcp_req_if request_bus();
	slcp_res_if result_bus();
	slcp_cfg_if cfg_bus();

	serial_led_command_parser uut (
		.clk    (clk),
		.arst_n (arst_n),
		.request(request_bus),
		.result (result_bus),
		.cfg    (cfg_bus)
	);

	led_result_t       expected_results[$];
	logic [BYTE_W-1:0] cmd_bytes [MAX_COMMAND_BYTES];
	int unsigned       cmd_len;
	logic [LED_W-1:0]  led_state;
	logic [LED_W-1:0]  blink_leds;
	int unsigned       phase;
	int unsigned       half_period;
	int                error_count = 0;
	int                item_count = 0;
	bit                no_gaps = 1'b0;
	bit                hold_request = 1'b0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic logic [LED_W-1:0] tail_target(int unsigned start, int unsigned len);
		int unsigned rest;
		rest = len - start;
		if (rest == 2 && cmd_bytes[start] == CHAR_STAR && cmd_bytes[start + 1] == CHAR_HASH)
			return '1;
		if (rest == 3 && cmd_bytes[start] == CHAR_ZERO && cmd_bytes[start + 1] >= CHAR_ONE &&
				cmd_bytes[start + 1] <= CHAR_EIGHT && cmd_bytes[start + 2] == CHAR_HASH)
			return LED_W'(1) << (cmd_bytes[start + 1] - CHAR_ONE);
		return '0;
	endfunction

	function automatic logic [LED_W-1:0] command_target(cmd_kind_t kind, int unsigned len);
		case (kind)
			CMD_ON: begin
				if (len >= 2 && cmd_bytes[0] == CHAR_O && cmd_bytes[1] == CHAR_N)
					return tail_target(2, len);
			end
			CMD_OFF: begin
				if (len >= 3 && cmd_bytes[0] == CHAR_O && cmd_bytes[1] == CHAR_F &&
						cmd_bytes[2] == CHAR_F)
					return tail_target(3, len);
			end
			CMD_BLINK: begin
				if (len >= 5 && cmd_bytes[0] == CHAR_B && cmd_bytes[1] == CHAR_L &&
						cmd_bytes[2] == CHAR_I && cmd_bytes[3] == CHAR_N && cmd_bytes[4] == CHAR_K)
					return tail_target(5, len);
			end
			default: ;
		endcase
		return '0;
	endfunction

	function automatic logic apply_command(int unsigned len);
		logic [LED_W-1:0] leds;
		leds = command_target(CMD_ON, len);
		if (leds != '0) begin
			led_state |= leds;
			blink_leds &= ~leds;
			return 1'b1;
		end
		leds = command_target(CMD_OFF, len);
		if (leds != '0) begin
			led_state &= ~leds;
			blink_leds &= ~leds;
			return 1'b1;
		end
		leds = command_target(CMD_BLINK, len);
		if (leds != '0) begin
			blink_leds |= leds;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic void advance_blink();
		if (blink_leds == '0)
			return;
		if (phase < half_period) begin
			led_state |= blink_leds;
			phase++;
		end else if (phase < 2 * half_period) begin
			led_state &= ~blink_leds;
			phase++;
		end else begin
			phase = 0;
		end
	endfunction

	function automatic void predict_leds(logic op, logic [BYTE_W-1:0] rx);
		led_result_t r;
		r.done = 1'b0;
		r.matched = 1'b0;
		if (op == OP_TICK) begin
			advance_blink();
		end else begin
			if (cmd_len >= MAX_COMMAND_BYTES)
				cmd_len = 0;
			cmd_bytes[cmd_len] = rx;
			cmd_len++;
			if (rx == CHAR_HASH || cmd_len >= MAX_COMMAND_BYTES) begin
				r.done = 1'b1;
				r.matched = apply_command(cmd_len);
				cmd_len = 0;
			end
		end
		r.leds = led_state;
		expected_results.push_back(r);
	endfunction

	function automatic int pick_gap();
		int r;
		if (no_gaps)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	task automatic send_item(input logic op, input logic [BYTE_W-1:0] rx);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			request_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		request_bus.valid <= 1'b1;
		request_bus.operation <= op;
		request_bus.rx_byte <= rx;
		@(posedge clk);
		while (!request_bus.ready) @(posedge clk);
		predict_leds(op, rx);
		item_count++;
	endtask

	task automatic send_ticks(input int count);
		repeat (count) send_item(OP_TICK, BYTE_W'($urandom_range(0, 255)));
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_item(OP_BYTE, s[i]);
	endtask

	task automatic send_bytes(input byte_seq_t seq, input int tick_pct);
		foreach (seq[i]) begin
			if ($urandom_range(0, 99) < tick_pct)
				send_ticks(1);
			send_item(OP_BYTE, seq[i]);
		end
	endtask

	task automatic wait_idle();
		request_bus.valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_half_period(input logic [HALF_W-1:0] value);
		wait_idle();
		cfg_bus.valid <= 1'b1;
		cfg_bus.blink_half_period <= value;
		@(posedge clk);
		while (!cfg_bus.ready) @(posedge clk);
		cfg_bus.valid <= 1'b0;
		half_period = value;
	endtask

	task automatic send_random_sequence();
		byte_seq_t seq;
		cmd_kind_t kind;
		int r;
		int pos;
		r = $urandom_range(0, 99);
		if (r < 88) begin
			kind = cmd_kind_t'(2'($urandom_range(0, 2)));
			case (kind)
				CMD_ON:  seq = '{CHAR_O, CHAR_N};
				CMD_OFF: seq = '{CHAR_O, CHAR_F, CHAR_F};
				default: seq = '{CHAR_B, CHAR_L, CHAR_I, CHAR_N, CHAR_K};
			endcase
			if ($urandom_range(0, 99) < 30) begin
				seq.push_back(CHAR_STAR);
			end else begin
				seq.push_back(CHAR_ZERO);
				seq.push_back(CHAR_ONE + BYTE_W'($urandom_range(0, 7)));
			end
			seq.push_back(CHAR_HASH);
			if (r >= 82) begin
				void'(seq.pop_back());
			end else if (r >= 76) begin
				pos = seq.size() - 2;
				if (seq[pos] == CHAR_STAR)
					seq[pos] = CHAR_ONE;
				else
					seq[pos] = $urandom_range(0, 1) ? CHAR_ZERO : CHAR_EIGHT + 8'd1;
			end else if (r >= 70) begin
				pos = $urandom_range(0, seq.size() - 1);
				seq[pos] = BYTE_W'($urandom_range(0, 255));
			end
		end else if (r < 94) begin
			repeat ($urandom_range(1, 12)) seq.push_back(BYTE_W'($urandom_range(0, 255)));
		end
		send_bytes(seq, 15);
		send_ticks((r >= 94) ? $urandom_range(1, 8) : $urandom_range(0, 3));
	endtask

	task automatic check_result();
		led_result_t want;
		led_result_t got;
		got.leds = result_bus.led_levels;
		got.done = result_bus.command_done;
		got.matched = result_bus.command_matched;
		if (expected_results.size() == 0) begin
			error_count++;
			if (error_count <= MAX_REPORTS)
				$display("unexpected result: leds=%h done=%b matched=%b",
					got.leds, got.done, got.matched);
			return;
		end
		want = expected_results.pop_front();
		if (got !== want) begin
			error_count++;
			if (error_count <= MAX_REPORTS)
				$display("mismatch: expected leds=%h done=%b matched=%b, got leds=%h done=%b matched=%b",
					want.leds, want.done, want.matched, got.leds, got.done, got.matched);
		end
	endtask

	initial begin : receiver
		int stall_left;
		int hold_left;
		stall_left = 0;
		hold_left = 0;
		result_bus.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (result_bus.valid && result_bus.ready)
				check_result();
			if (hold_request) begin
				hold_left = HOLD_CYCLES;
				hold_request = 1'b0;
			end
			if (hold_left > 0) begin
				result_bus.ready <= 1'b0;
				hold_left--;
			end else if (stall_left > 0) begin
				result_bus.ready <= 1'b0;
				stall_left--;
			end else begin
				stall_left = pick_gap();
				result_bus.ready <= (stall_left == 0);
				if (stall_left > 0)
					stall_left--;
			end
		end
	end

	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if ((request_bus.valid && request_bus.ready) || (result_bus.valid && result_bus.ready) ||
					(cfg_bus.valid && cfg_bus.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	task automatic test_empty_mask();
		send_ticks(2);
		send_item(OP_BYTE, CHAR_HASH);
	endtask

	task automatic test_led_commands();
		send_text("ON*#");
		send_text("OFF08#");
		send_text("BLINK01#");
		send_ticks(3);
	endtask

	task automatic test_command_overflow();
		send_item(OP_BYTE, 8'h00);
		send_item(OP_BYTE, 8'hFF);
		repeat (8) send_item(OP_BYTE, CHAR_O);
	endtask

	task automatic test_half_period_change();
		write_half_period(16'd1);
		send_ticks(4);
		write_half_period(16'd0);
		send_ticks(2);
		write_half_period(16'hFFFF);
		send_ticks(2);
	endtask

	task automatic test_random_traffic(input logic [HALF_W-1:0] value, input int count);
		int target;
		write_half_period(value);
		target = item_count + count;
		while (item_count < target) send_random_sequence();
	endtask

	task automatic test_back_to_back(input int count);
		int target;
		no_gaps = 1'b1;
		target = item_count + count;
		while (item_count < target) send_random_sequence();
		no_gaps = 1'b0;
	endtask

	task automatic test_output_stall(input int count);
		int target;
		no_gaps = 1'b1;
		hold_request = 1'b1;
		target = item_count + count;
		while (item_count < target) send_random_sequence();
		no_gaps = 1'b0;
	endtask

	initial begin
		request_bus.valid = 1'b0;
		request_bus.operation = OP_BYTE;
		request_bus.rx_byte = '0;
		cfg_bus.valid = 1'b0;
		cfg_bus.blink_half_period = HALF_PERIOD_RESET;
		cmd_len = 0;
		led_state = '0;
		blink_leds = '0;
		phase = 0;
		half_period = HALF_PERIOD_RESET;
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_mask();
		test_led_commands();
		test_command_overflow();
		test_half_period_change();
		test_random_traffic(16'd1, 160);
		test_back_to_back(60);
		test_random_traffic(16'd3, 140);
		test_output_stall(40);
		test_random_traffic(16'd0, 80);
		test_random_traffic(16'hFFFF, 80);
		test_random_traffic(HALF_W'($urandom_range(2, 6)), 160);

		wait_idle();
		if (error_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ----- filelist.f -----
src/slcp_pkg.sv
src/slcp_if.sv
src/slcp_cmd_decode.sv
src/slcp_led_ctrl.sv
src/serial_led_command_parser.sv
tb/tb_serial_led_command_parser.sv
